// ===== rtl/mpr_pkg.sv =====
// Package for the multichannel power ramp core.
// Holds the command codes, register indexes, level constants and FSM state type.
// No dependencies.
package mpr_pkg;

    typedef logic [7:0] level_t;
    typedef logic [3:0] cmd_code_t;
    typedef logic [2:0] cfg_idx_t;

    localparam cmd_code_t CMD_SET_TARGET      = 4'd0;
    localparam cmd_code_t CMD_INC_ALL_TARGETS = 4'd1;
    localparam cmd_code_t CMD_DEC_ALL_TARGETS = 4'd2;
    localparam cmd_code_t CMD_SET_ALL_TARGETS = 4'd3;
    localparam cmd_code_t CMD_SET_OUTPUT      = 4'd4;
    localparam cmd_code_t CMD_SET_ALL_OUTPUTS = 4'd5;
    localparam cmd_code_t CMD_COPY_TARGETS    = 4'd6;
    localparam cmd_code_t CMD_RAMP_UP         = 4'd7;
    localparam cmd_code_t CMD_RAMP_DOWN       = 4'd8;
    localparam cmd_code_t CMD_PATTERN_STEP    = 4'd9;
    localparam cmd_code_t CMD_INC_TARGET      = 4'd10;
    localparam cmd_code_t CMD_DEC_TARGET      = 4'd11;
    localparam cmd_code_t CMD_INC_OUTPUT      = 4'd12;
    localparam cmd_code_t CMD_DEC_OUTPUT      = 4'd13;

    localparam cfg_idx_t CFG_RAMP_UP_DIV_A   = 3'd0;
    localparam cfg_idx_t CFG_RAMP_UP_DIV_B   = 3'd1;
    localparam cfg_idx_t CFG_RAMP_DOWN_DIV_A = 3'd2;
    localparam cfg_idx_t CFG_RAMP_DOWN_DIV_B = 3'd3;
    localparam cfg_idx_t CFG_BANK_SELECT     = 3'd4;

    localparam level_t     LEVEL_MAX     = 8'd255;
    localparam level_t     PATTERN_LEVEL = 8'd100;
    localparam logic [3:0] PATTERN_LEN   = 4'd8;
    localparam logic [2:0] DIV_LAST      = 3'd7;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_CALC  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_APPLY = 7'b0010000,
        S_FETCH = 7'b0100000,
        S_LOAD  = 7'b1000000
    } state_t;

endpackage

// ===== rtl/multichannel_power_ramp_core.sv =====
// Top level of the multichannel power ramp core: per-channel target and output
// level memories, a channel sequencer and a shared 8-bit restoring divider.
// Depends on mpr_pkg.
// A single-channel word passes through the read, calculate, fetch and load states; an
// all-channel word repeats read and calculate for every channel, and a ramp word adds
// the divide steps and an apply step per channel (none for a ramp-up channel whose
// target is zero). The divider yields one quotient bit per cycle. One word is worked
// on at a time; the next one is accepted while a result still waits. Reset clears
// all levels through per-entry valid bits, clears the pattern position and sets the
// registers to their reset values at once; no clearing pass is needed.
module multichannel_power_ramp_core #(
    parameter int CHANNELS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mpr_pkg::cmd_code_t cmd,
    input  logic [2:0]        channel,
    input  mpr_pkg::level_t   amount,
    output logic              out_valid,
    input  logic              out_stall,
    output mpr_pkg::level_t   target_level,
    output mpr_pkg::level_t   output_level,
    output logic              all_targets_zero,
    output logic              disable_event,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  mpr_pkg::cfg_idx_t cfg_index,
    input  logic [7:0]        cfg_data
);
    import mpr_pkg::*;

    localparam int CLOG = $clog2(CHANNELS);
    localparam int AW = (CLOG > 0) ? CLOG : 1;
    localparam int KW = (CLOG > 3) ? CLOG : 3;
    localparam logic [KW:0] CH_LIM = (KW + 1)'(CHANNELS);
    localparam logic [KW-1:0] LAST_CH = KW'(CHANNELS - 1);

    state_t state_reg, state_next;

    level_t up_div_a_reg, up_div_b_reg, down_div_a_reg, down_div_b_reg;
    logic bank_reg;

    cmd_code_t cmd_reg;
    logic [2:0] ch_reg;
    level_t amt_reg;
    logic [3:0] pat_reg;
    logic [3:0] pattern_index_reg;
    logic [KW-1:0] idx_reg, end_reg;
    logic down_reg;
    logic disable_seen_reg;

    level_t div_d_reg, div_rem_reg, div_quo_reg;
    logic [2:0] div_cnt_reg;

    level_t tmem [CHANNELS];
    level_t omem [CHANNELS];
    logic [CHANNELS-1:0] tvalid_reg, ovalid_reg, nz_reg;
    level_t rd_t_reg, rd_o_reg;
    logic rd_t_hit_reg, rd_o_hit_reg;

    level_t target_level_reg, output_level_reg;
    logic out_valid_reg, all_zero_reg, disable_out_reg;

    logic in_accept, out_accept, rd_en, idx_ok, rd_ok, last_step, go_div;
    logic [KW-1:0] rd_addr, idx_step;
    logic [AW-1:0] wa;
    level_t t_eff, o_eff, t_wd, o_wd, sel_div, pat_val, step_val;
    logic t_we, o_we;
    logic [8:0] t_sum, o_sum, ramp_sum, div_trial;
    level_t t_add, t_sub, o_add, o_sub;
    logic [CHANNELS-1:0] nz_after;

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    assign out_valid = out_valid_reg;
    assign target_level = target_level_reg;
    assign output_level = output_level_reg;
    assign all_targets_zero = all_zero_reg;
    assign disable_event = disable_out_reg;

    assign t_eff = rd_t_hit_reg ? rd_t_reg : '0;
    assign o_eff = rd_o_hit_reg ? rd_o_reg : '0;
    assign idx_ok = ({1'b0, idx_reg} < CH_LIM);
    assign last_step = (idx_reg == end_reg);
    assign idx_step = down_reg ? (idx_reg - KW'(1)) : (idx_reg + KW'(1));
    assign wa = idx_reg[AW-1:0];
    assign rd_en = (state_reg == S_READ) || (state_reg == S_FETCH);
    assign rd_addr = (state_reg == S_FETCH) ? KW'(ch_reg) : idx_reg;
    assign rd_ok = ({1'b0, rd_addr} < CH_LIM);

    always_comb
    begin
        if (cmd == CMD_RAMP_UP)
        begin
            sel_div = bank_reg ? up_div_b_reg : up_div_a_reg;
        end
        else
        begin
            sel_div = bank_reg ? down_div_b_reg : down_div_a_reg;
        end
        if (sel_div == 8'd0)
        begin
            sel_div = 8'd1;
        end
    end

    assign t_sum = {1'b0, t_eff} + {1'b0, amt_reg};
    assign o_sum = {1'b0, o_eff} + {1'b0, amt_reg};
    assign t_add = t_sum[8] ? LEVEL_MAX : t_sum[7:0];
    assign o_add = o_sum[8] ? LEVEL_MAX : o_sum[7:0];
    assign t_sub = (t_eff >= amt_reg) ? (t_eff - amt_reg) : 8'd0;
    assign o_sub = (o_eff >= amt_reg) ? (o_eff - amt_reg) : 8'd0;

    assign pat_val = (pat_reg >= PATTERN_LEN) ? PATTERN_LEVEL :
                     ((idx_reg == KW'(pat_reg[2:0])) ? PATTERN_LEVEL : 8'd0);

    assign step_val = (div_quo_reg == 8'd0) ? 8'd1 : div_quo_reg;
    assign ramp_sum = {1'b0, o_eff} + {1'b0, step_val};
    assign div_trial = {div_rem_reg, div_quo_reg[7]} - {1'b0, div_d_reg};

    always_comb
    begin
        t_we = 1'b0;
        o_we = 1'b0;
        t_wd = t_eff;
        o_wd = o_eff;
        go_div = 1'b0;
        if ((state_reg == S_CALC) && idx_ok)
        begin
            case (cmd_reg)
                CMD_SET_TARGET, CMD_SET_ALL_TARGETS:
                begin
                    t_we = 1'b1;
                    t_wd = amt_reg;
                end
                CMD_INC_TARGET, CMD_INC_ALL_TARGETS:
                begin
                    t_we = 1'b1;
                    t_wd = t_add;
                end
                CMD_DEC_TARGET, CMD_DEC_ALL_TARGETS:
                begin
                    t_we = 1'b1;
                    t_wd = t_sub;
                end
                CMD_PATTERN_STEP:
                begin
                    t_we = 1'b1;
                    t_wd = pat_val;
                end
                CMD_SET_OUTPUT, CMD_SET_ALL_OUTPUTS:
                begin
                    o_we = 1'b1;
                    o_wd = amt_reg;
                end
                CMD_COPY_TARGETS:
                begin
                    o_we = 1'b1;
                    o_wd = t_eff;
                end
                CMD_INC_OUTPUT:
                begin
                    o_we = 1'b1;
                    o_wd = o_add;
                end
                CMD_DEC_OUTPUT:
                begin
                    o_we = 1'b1;
                    o_wd = o_sub;
                end
                CMD_RAMP_UP:
                begin
                    go_div = (t_eff != 8'd0);
                end
                CMD_RAMP_DOWN:
                begin
                    go_div = 1'b1;
                end
                default:
                begin
                    t_we = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_APPLY)
        begin
            o_we = 1'b1;
            if (cmd_reg == CMD_RAMP_UP)
            begin
                o_wd = (ramp_sum <= {1'b0, t_eff}) ? ramp_sum[7:0] : t_eff;
            end
            else
            begin
                o_wd = (o_eff >= step_val) ? (o_eff - step_val) : 8'd0;
            end
        end
    end

    always_comb
    begin
        nz_after = nz_reg;
        nz_after[wa] = (t_wd != 8'd0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (go_div)
                begin
                    state_next = S_DIV;
                end
                else if (last_step)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = last_step ? S_FETCH : S_READ;
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            up_div_a_reg <= 8'd1;
            up_div_b_reg <= 8'd5;
            down_div_a_reg <= 8'd1;
            down_div_b_reg <= 8'd5;
            bank_reg <= 1'b0;
            pattern_index_reg <= '0;
            disable_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            tvalid_reg <= '0;
            ovalid_reg <= '0;
            nz_reg <= '0;
            rd_t_hit_reg <= 1'b0;
            rd_o_hit_reg <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RAMP_UP_DIV_A:   up_div_a_reg <= cfg_data;
                    CFG_RAMP_UP_DIV_B:   up_div_b_reg <= cfg_data;
                    CFG_RAMP_DOWN_DIV_A: down_div_a_reg <= cfg_data;
                    CFG_RAMP_DOWN_DIV_B: down_div_b_reg <= cfg_data;
                    CFG_BANK_SELECT:     bank_reg <= cfg_data[0];
                    default:             bank_reg <= bank_reg;
                endcase
            end

            if (in_accept)
            begin
                disable_seen_reg <= 1'b0;
                if (cmd == CMD_PATTERN_STEP)
                begin
                    if (pattern_index_reg >= PATTERN_LEN)
                    begin
                        pattern_index_reg <= '0;
                    end
                    else
                    begin
                        pattern_index_reg <= pattern_index_reg + 4'd1;
                    end
                end
            end
            else if (t_we && (nz_after == '0))
            begin
                disable_seen_reg <= 1'b1;
            end

            if (t_we)
            begin
                tvalid_reg[wa] <= 1'b1;
                nz_reg <= nz_after;
            end
            if (o_we)
            begin
                ovalid_reg[wa] <= 1'b1;
            end

            if (rd_en)
            begin
                rd_t_hit_reg <= rd_ok && tvalid_reg[rd_addr[AW-1:0]];
                rd_o_hit_reg <= rd_ok && ovalid_reg[rd_addr[AW-1:0]];
            end

            if (state_reg == S_CALC)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 3'd1;
            end

            if ((state_reg == S_LOAD) && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tmem[wa] <= t_wd;
        end
        if (o_we)
        begin
            omem[wa] <= o_wd;
        end
        if (rd_en)
        begin
            rd_t_reg <= tmem[rd_addr[AW-1:0]];
            rd_o_reg <= omem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= cmd;
            ch_reg <= channel;
            amt_reg <= amount;
            pat_reg <= pattern_index_reg;
            div_d_reg <= sel_div;
            down_reg <= 1'b0;
            case (cmd)
                CMD_SET_TARGET, CMD_SET_OUTPUT, CMD_INC_TARGET, CMD_DEC_TARGET,
                CMD_INC_OUTPUT, CMD_DEC_OUTPUT:
                begin
                    idx_reg <= KW'(channel);
                    end_reg <= KW'(channel);
                end
                CMD_INC_ALL_TARGETS, CMD_DEC_ALL_TARGETS, CMD_SET_ALL_TARGETS,
                CMD_SET_ALL_OUTPUTS, CMD_COPY_TARGETS, CMD_RAMP_UP, CMD_RAMP_DOWN:
                begin
                    idx_reg <= '0;
                    end_reg <= LAST_CH;
                end
                CMD_PATTERN_STEP:
                begin
                    if ((pattern_index_reg == 4'd0) || (pattern_index_reg >= PATTERN_LEN))
                    begin
                        idx_reg <= '0;
                        end_reg <= LAST_CH;
                    end
                    else
                    begin
                        // The new channel is lit before the previous one is cleared.
                        idx_reg <= KW'(pattern_index_reg[2:0]);
                        end_reg <= KW'(pattern_index_reg[2:0]) - KW'(1);
                        down_reg <= 1'b1;
                    end
                end
                default:
                begin
                    idx_reg <= KW'(channel);
                    end_reg <= KW'(channel);
                end
            endcase
        end
        else if (((state_reg == S_CALC) && !go_div) || (state_reg == S_APPLY))
        begin
            if (!last_step)
            begin
                idx_reg <= idx_step;
            end
        end

        if (state_reg == S_CALC)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= t_eff;
        end
        else if (state_reg == S_DIV)
        begin
            if (!div_trial[8])
            begin
                div_rem_reg <= div_trial[7:0];
                div_quo_reg <= {div_quo_reg[6:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= {div_rem_reg[6:0], div_quo_reg[7]};
                div_quo_reg <= {div_quo_reg[6:0], 1'b0};
            end
        end

        if ((state_reg == S_LOAD) && (!out_valid_reg || !out_stall))
        begin
            target_level_reg <= t_eff;
            output_level_reg <= o_eff;
            all_zero_reg <= (nz_reg == '0);
            disable_out_reg <= disable_seen_reg;
        end
    end

    a_target_write_in_calc: assert property (
        @(posedge clk) disable iff (!rst_n)
        t_we |-> (state_reg == S_CALC)
    ) else $error("target memory written outside the calculate state");

    a_output_write_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        o_we |-> ((state_reg == S_CALC) || (state_reg == S_APPLY))
    ) else $error("output memory written outside calculate or apply");

    a_divider_length: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV) && (div_cnt_reg == DIV_LAST)) |=> (state_reg == S_APPLY)
    ) else $error("divider did not hand over after eight steps");

    a_accept_starts_walk: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept |=> ((state_reg == S_READ) && !disable_seen_reg)
    ) else $error("accepted word did not start a clean channel walk");

endmodule

// ===== tb/sv/tb_multichannel_power_ramp_core.sv =====
// Self-checking testbench for multichannel_power_ramp_core: a directed command table, then
// random command words under several divisor settings, checked against a level model here.
// Depends on mpr_pkg and the core RTL.
module tb_multichannel_power_ramp_core;
    import mpr_pkg::*;

    localparam int CHANNELS = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;
    localparam int PHASES = 7;
    localparam int WORDS_PER_PHASE = 90;
    localparam int MAX_GAP = 17;
    localparam cmd_code_t CMD_UNUSED_TOP = 4'd15;
    localparam cfg_idx_t CFG_SPARE_FIRST = 3'd5;
    localparam cfg_idx_t CFG_SPARE_LAST = 3'd7;

    typedef struct packed {
        level_t      target_lvl;
        level_t      output_lvl;
        logic        all_zero;
        logic        zeroed;
        logic [31:0] seq;
    } level_word_t;

    typedef struct packed {
        cmd_code_t   op;
        logic [2:0]  ch;
        level_t      amt;
        bit          known;
        level_word_t due;
    } directed_row_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    cmd_code_t  cmd = CMD_SET_TARGET;
    logic [2:0] channel = '0;
    level_t     amount = '0;
    logic       out_valid;
    logic       out_stall = 1'b1;
    level_t     target_level;
    level_t     output_level;
    logic       all_targets_zero;
    logic       disable_event;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_idx_t   cfg_index = CFG_RAMP_UP_DIV_A;
    logic [7:0] cfg_data = '0;

    level_t        target_model [CHANNELS];
    level_t        output_model [CHANNELS];
    logic [3:0]    pattern_pos;
    level_t        up_div_a;
    level_t        up_div_b;
    level_t        down_div_a;
    level_t        down_div_b;
    logic          bank_b;
    logic          write_zeroed;

    level_word_t   levels_due [$];
    directed_row_t directed_rows [$];
    level_word_t   oldest;
    bit            calm = 1'b0;
    int            words_sent = 0;
    int            results_seen = 0;
    int            mismatches = 0;
    int            pauses = 0;
    int            cycle_count = 0;
    int unsigned   hold;

    multichannel_power_ramp_core #(
        .CHANNELS(CHANNELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .channel(channel),
        .amount(amount),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .target_level(target_level),
        .output_level(output_level),
        .all_targets_zero(all_targets_zero),
        .disable_event(disable_event),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("tb_multichannel_power_ramp_core: FAIL");
        $finish;
    end

    function automatic level_t sat_add(int unsigned a, int unsigned b);
        return (a + b > LEVEL_MAX) ? LEVEL_MAX : level_t'(a + b);
    endfunction

    function automatic level_t sat_sub(int unsigned a, int unsigned b);
        return (a >= b) ? level_t'(a - b) : level_t'(0);
    endfunction

    function automatic int unsigned ramp_amount(int unsigned lvl, int unsigned div);
        if (div == 0)
            div = 1;
        return (lvl < div) ? 1 : lvl / div;
    endfunction

    function automatic bit targets_zero();
        int j;
        for (j = 0; j < CHANNELS; j++)
            if (target_model[j] != 0)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void store_target(int idx, level_t v);
        target_model[idx] = v;
        if (targets_zero())
            write_zeroed = 1'b1;
    endfunction

    function automatic void advance_pattern();
        int j;
        if (pattern_pos == 0)
        begin
            store_target(0, PATTERN_LEVEL);
            for (j = 1; j < CHANNELS; j++)
                store_target(j, '0);
            pattern_pos = 4'd1;
        end
        else if (pattern_pos < PATTERN_LEN)
        begin
            store_target(pattern_pos, PATTERN_LEVEL);
            store_target(pattern_pos - 1, '0);
            pattern_pos = pattern_pos + 4'd1;
        end
        else
        begin
            for (j = 0; j < CHANNELS; j++)
                store_target(j, PATTERN_LEVEL);
            pattern_pos = '0;
        end
    endfunction

    function automatic level_word_t predict_levels(cmd_code_t op, logic [2:0] ch, level_t amt);
        level_word_t r;
        int          j;
        int unsigned div;
        int unsigned step;
        int unsigned lvl;
        int unsigned cur;
        write_zeroed = 1'b0;
        case (op)
            CMD_SET_TARGET:
                store_target(ch, amt);
            CMD_INC_ALL_TARGETS:
                for (j = 0; j < CHANNELS; j++)
                    store_target(j, sat_add(target_model[j], amt));
            CMD_DEC_ALL_TARGETS:
                for (j = 0; j < CHANNELS; j++)
                    store_target(j, sat_sub(target_model[j], amt));
            CMD_SET_ALL_TARGETS:
                for (j = 0; j < CHANNELS; j++)
                    store_target(j, amt);
            CMD_SET_OUTPUT:
                output_model[ch] = amt;
            CMD_SET_ALL_OUTPUTS:
                for (j = 0; j < CHANNELS; j++)
                    output_model[j] = amt;
            CMD_COPY_TARGETS:
                for (j = 0; j < CHANNELS; j++)
                    output_model[j] = target_model[j];
            CMD_RAMP_UP:
            begin
                div = bank_b ? up_div_b : up_div_a;
                for (j = 0; j < CHANNELS; j++)
                begin
                    lvl = target_model[j];
                    if (lvl != 0)
                    begin
                        step = ramp_amount(lvl, div);
                        cur = output_model[j];
                        output_model[j] = (cur + step <= lvl) ? level_t'(cur + step)
                                                              : level_t'(lvl);
                    end
                end
            end
            CMD_RAMP_DOWN:
            begin
                div = bank_b ? down_div_b : down_div_a;
                for (j = 0; j < CHANNELS; j++)
                begin
                    step = ramp_amount(target_model[j], div);
                    output_model[j] = sat_sub(output_model[j], step);
                end
            end
            CMD_PATTERN_STEP:
                advance_pattern();
            CMD_INC_TARGET:
                store_target(ch, sat_add(target_model[ch], amt));
            CMD_DEC_TARGET:
                store_target(ch, sat_sub(target_model[ch], amt));
            CMD_INC_OUTPUT:
                output_model[ch] = sat_add(output_model[ch], amt);
            CMD_DEC_OUTPUT:
                output_model[ch] = sat_sub(output_model[ch], amt);
            default: ;
        endcase
        r.target_lvl = target_model[ch];
        r.output_lvl = output_model[ch];
        r.all_zero = targets_zero();
        r.zeroed = write_zeroed;
        r.seq = '0;
        return r;
    endfunction

    function automatic void add_row(cmd_code_t op, logic [2:0] ch, level_t amt, bit known,
                                    level_t t, level_t o, logic z, logic d);
        directed_row_t row;
        row.op = op;
        row.ch = ch;
        row.amt = amt;
        row.known = known;
        row.due.target_lvl = t;
        row.due.output_lvl = o;
        row.due.all_zero = z;
        row.due.zeroed = d;
        row.due.seq = '0;
        directed_rows.push_back(row);
    endfunction

    task automatic send_word(cmd_code_t op, logic [2:0] ch, level_t amt, bit known,
                             level_word_t typed);
        int unsigned gap;
        level_word_t due;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        channel <= ch;
        amount <= amt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        due = predict_levels(op, ch, amt);
        if (known)
            due = typed;
        due.seq = words_sent;
        levels_due.push_back(due);
        words_sent++;
    endtask

    task automatic finish_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (levels_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_RAMP_UP_DIV_A:   up_div_a = data;
            CFG_RAMP_UP_DIV_B:   up_div_b = data;
            CFG_RAMP_DOWN_DIV_A: down_div_a = data;
            CFG_RAMP_DOWN_DIV_B: down_div_b = data;
            CFG_BANK_SELECT:     bank_b = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int phase);
        case (phase)
            1:
            begin
                write_register(CFG_RAMP_UP_DIV_A, LEVEL_MAX);
                write_register(CFG_RAMP_DOWN_DIV_A, LEVEL_MAX);
                write_register(CFG_BANK_SELECT, 8'h00);
            end
            2:
            begin
                write_register(CFG_RAMP_UP_DIV_B, 8'd0);
                write_register(CFG_RAMP_DOWN_DIV_B, 8'd0);
                write_register(CFG_BANK_SELECT, 8'hFF);
            end
            3:
            begin
                write_register(CFG_RAMP_UP_DIV_B, LEVEL_MAX);
                write_register(CFG_RAMP_DOWN_DIV_B, 8'd1);
                write_register(cfg_idx_t'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                               8'($urandom_range(0, 255)));
                write_register(CFG_BANK_SELECT, 8'h01);
            end
            4:
            begin
                write_register(CFG_RAMP_UP_DIV_A, 8'($urandom_range(0, 255)));
                write_register(CFG_RAMP_UP_DIV_B, 8'($urandom_range(0, 255)));
                write_register(CFG_RAMP_DOWN_DIV_A, 8'($urandom_range(0, 255)));
                write_register(CFG_RAMP_DOWN_DIV_B, 8'($urandom_range(0, 255)));
                write_register(CFG_BANK_SELECT, 8'hFE);
            end
            5:
            begin
                write_register(CFG_RAMP_UP_DIV_A, 8'd0);
                write_register(CFG_RAMP_DOWN_DIV_A, 8'd0);
                write_register(CFG_BANK_SELECT, 8'h00);
            end
            6:
            begin
                write_register(CFG_RAMP_UP_DIV_A, 8'($urandom_range(1, 16)));
                write_register(CFG_RAMP_UP_DIV_B, 8'($urandom_range(0, 255)));
                write_register(CFG_RAMP_DOWN_DIV_A, 8'($urandom_range(1, 16)));
                write_register(CFG_RAMP_DOWN_DIV_B, 8'($urandom_range(0, 255)));
                write_register(cfg_idx_t'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                               8'($urandom_range(0, 255)));
                write_register(CFG_BANK_SELECT, 8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        if (phase != 0)
            cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string name, int seq, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: word %0d %s expected %0d, actual %0d", $time, seq, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (levels_due.size() == 0)
            begin
                $display("%0t: result word with none expected, expected none, actual %0d/%0d",
                         $time, target_level, output_level);
                mismatches++;
            end
            else
            begin
                oldest = levels_due.pop_front();
                check_field("target_level", oldest.seq, oldest.target_lvl, target_level);
                check_field("output_level", oldest.seq, oldest.output_lvl, output_level);
                check_field("all_targets_zero", oldest.seq, oldest.all_zero, all_targets_zero);
                check_field("disable_event", oldest.seq, oldest.zeroed, disable_event);
            end
        end
    end

    initial
    begin
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        int          i;
        int          phase;
        int unsigned pick;
        cmd_code_t   op;
        logic [2:0]  ch;
        level_t      amt;

        for (i = 0; i < CHANNELS; i++)
        begin
            target_model[i] = '0;
            output_model[i] = '0;
        end
        pattern_pos = '0;
        up_div_a = 8'd1;
        up_div_b = 8'd5;
        down_div_a = 8'd1;
        down_div_b = 8'd5;
        bank_b = 1'b0;
        write_zeroed = 1'b0;

        add_row(CMD_SET_OUTPUT, 3'd0, 8'd0, 1'b1, 8'd0, 8'd0, 1'b1, 1'b0);
        add_row(CMD_SET_TARGET, 3'd7, LEVEL_MAX, 1'b1, LEVEL_MAX, 8'd0, 1'b0, 1'b0);
        add_row(CMD_INC_TARGET, 3'd7, LEVEL_MAX, 1'b1, LEVEL_MAX, 8'd0, 1'b0, 1'b0);
        add_row(CMD_COPY_TARGETS, 3'd7, 8'd0, 1'b1, LEVEL_MAX, LEVEL_MAX, 1'b0, 1'b0);
        add_row(CMD_INC_OUTPUT, 3'd7, 8'd1, 1'b1, LEVEL_MAX, LEVEL_MAX, 1'b0, 1'b0);
        add_row(CMD_DEC_TARGET, 3'd7, LEVEL_MAX, 1'b1, 8'd0, LEVEL_MAX, 1'b1, 1'b1);
        add_row(CMD_UNUSED_TOP, 3'd7, 8'h55, 1'b1, 8'd0, LEVEL_MAX, 1'b1, 1'b0);
        add_row(CMD_SET_ALL_TARGETS, 3'd2, 8'd200, 1'b1, 8'd200, 8'd0, 1'b0, 1'b0);
        add_row(CMD_INC_ALL_TARGETS, 3'd2, 8'd100, 1'b1, LEVEL_MAX, 8'd0, 1'b0, 1'b0);
        add_row(CMD_DEC_ALL_TARGETS, 3'd2, LEVEL_MAX, 1'b1, 8'd0, 8'd0, 1'b1, 1'b1);
        add_row(CMD_DEC_ALL_TARGETS, 3'd2, 8'd0, 1'b1, 8'd0, 8'd0, 1'b1, 1'b1);
        add_row(CMD_SET_ALL_TARGETS, 3'd1, 8'd128, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(CMD_RAMP_UP, 3'd1, 8'd0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(CMD_INC_OUTPUT, 3'd1, LEVEL_MAX, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(CMD_RAMP_UP, 3'd1, 8'd0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(CMD_SET_ALL_OUTPUTS, 3'd4, 8'd77, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(CMD_RAMP_DOWN, 3'd1, 8'd0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(CMD_DEC_OUTPUT, 3'd1, LEVEL_MAX, 1'b0, '0, '0, 1'b0, 1'b0);
        for (i = 0; i <= CHANNELS; i++)
            add_row(CMD_PATTERN_STEP, 3'(i), 8'(i), 1'b0, '0, '0, 1'b0, 1'b0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < directed_rows.size(); i++)
            send_word(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].amt,
                      directed_rows[i].known, directed_rows[i].due);

        for (phase = 0; phase < PHASES; phase++)
        begin
            finish_results();
            apply_setting(phase);
            for (i = 0; i < WORDS_PER_PHASE; i++)
            begin
                if (i % 30 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 39) == 0)
                begin
                    finish_results();
                    pauses++;
                end
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    op = CMD_RAMP_UP;
                else if (pick < 32)
                    op = CMD_RAMP_DOWN;
                else if (pick < 38)
                    op = CMD_PATTERN_STEP;
                else
                    op = cmd_code_t'($urandom_range(CMD_SET_TARGET, CMD_UNUSED_TOP));
                ch = 3'($urandom_range(0, CHANNELS - 1));
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    amt = '0;
                else if (pick < 24)
                    amt = LEVEL_MAX;
                else if (pick < 50)
                    amt = 8'($urandom_range(1, 8));
                else
                    amt = 8'($urandom_range(0, 255));
                send_word(op, ch, amt, 1'b0, '0);
            end
        end

        finish_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d command words (%0d from the directed table) over %0d divisor settings,",
                 words_sent, directed_rows.size(), PHASES);
        $display("with %0d drain pauses; %0d result words checked, %0d field mismatches.",
                 pauses, results_seen, mismatches);
        if (mismatches == 0)
            $display("tb_multichannel_power_ramp_core: PASS");
        else
            $display("tb_multichannel_power_ramp_core: FAIL");
        $finish;
    end

endmodule
